// File: rtl/point_line_distance_3d_macros.svh
// ------------------------------------------------------------------------
// point_line_distance_3d_macros
// assertion helpers; expect signals clock and reset in scope
// ------------------------------------------------------------------------
`ifndef POINT_LINE_DISTANCE_3D_MACROS_SVH
`define POINT_LINE_DISTANCE_3D_MACROS_SVH

// same-cycle implication
`define PLDA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PLDA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/plda_pkg.sv
// ------------------------------------------------------------------------
// plda_pkg
// widths and shared types of the point to line distance pipeline
// ------------------------------------------------------------------------
package plda_pkg;

   // coordinate width; 8 fractional bits, scale carries through untouched
   localparam int COORD_BITS = 20;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int MAG_W      = COORD_BITS;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int S_W        = SUM_W + 1;
   localparam int HALF_W     = SUM_W / 2;
   localparam int NUM_W      = 2 * SUM_W;
   localparam int QUO_W      = SUM_W;
   localparam int ROOT_W     = QUO_W / 2;
   localparam int OUT_W      = 21;
   localparam int MAX_W      = (ROOT_W > OUT_W) ? ROOT_W : OUT_W;
   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   typedef logic [COORD_BITS-1:0] coord_type;

   // control that travels with each stage
   typedef struct packed {
      logic valid;
      logic degen;
   } plda_ctl_type;

endpackage

// File: rtl/plda_if.sv
// ------------------------------------------------------------------------
// plda_if
// request and response channel interfaces, valid/ready handshake
// ------------------------------------------------------------------------
interface plda_req_if import plda_pkg::*;;
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   coord_type point_z;
   coord_type anchor_a_x;
   coord_type anchor_a_y;
   coord_type anchor_a_z;
   coord_type anchor_b_x;
   coord_type anchor_b_y;
   coord_type anchor_b_z;

   modport source (output valid, point_x, point_y, point_z, anchor_a_x, anchor_a_y,
                   anchor_a_z, anchor_b_x, anchor_b_y, anchor_b_z, input ready);
   modport sink (input valid, point_x, point_y, point_z, anchor_a_x, anchor_a_y,
                 anchor_a_z, anchor_b_x, anchor_b_y, anchor_b_z, output ready);
endinterface

interface plda_rsp_if import plda_pkg::*;;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] line_distance;
   logic             degenerate;

   modport source (output valid, line_distance, degenerate, input ready);
   modport sink (input valid, line_distance, degenerate, output ready);
endinterface

// File: rtl/plda_front.sv
// ------------------------------------------------------------------------
// plda_front
// seven-stage front end: differences, squares, dot product, wide
// products and the numerator / divisor pair for the divider
// ------------------------------------------------------------------------
module plda_front import plda_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [2:0][COORD_BITS-1:0]  in_p,
   input  logic [2:0][COORD_BITS-1:0]  in_a,
   input  logic [2:0][COORD_BITS-1:0]  in_b,
   output plda_ctl_type                out_ctl,
   output logic [NUM_W-1:0]            out_num,
   output logic [SUM_W-1:0]            out_den
);

   logic [6:0] valid_ff;
   logic       degen4_ff, degen5_ff, degen6_ff, degen7_ff;

   // stage 1: d = a - p, e = a - b
   logic [2:0][DIFF_W-1:0] d_in, e_in, d_ff, e_ff;
   // stage 2: squares and cross products
   logic [2:0][SQ_W-1:0]   sqd_in, sqe_in, pr_in, sqd_ff, sqe_ff, pr_ff;
   logic [2:0]             neg_in, neg_ff;
   logic [2:0][DIFF_W-1:0] dn, en;
   logic [2:0][MAG_W-1:0]  md, me;
   // stage 3: sums
   logic [SUM_W-1:0]       dd_in, ee_in, dd3_ff, ee3_ff;
   logic [S_W-1:0]         s_in, s_ff;
   // stage 4: magnitude of the dot product
   logic [S_W-1:0]         s_neg;
   logic [SUM_W-1:0]       sab_in, sab_ff, dd4_ff, ee4_ff;
   // stage 5: partial products
   logic [SUM_W-1:0]       pe_hh_ff, pe_hl_ff, pe_lh_ff, pe_ll_ff;
   logic [SUM_W-1:0]       ps_hh_ff, ps_hl_ff, ps_lh_ff, ps_ll_ff;
   logic [SUM_W-1:0]       dd5_ff, ee5_ff;
   // stage 6: wide products
   logic [NUM_W-1:0]       pde_in, pss_in, pde_ff, pss_ff;
   logic [SUM_W-1:0]       dd6_ff, ee6_ff;
   // stage 7
   logic [NUM_W-1:0]       num_ff;
   logic [SUM_W-1:0]       den_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   // differences, sign extended
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k] = {in_a[k][COORD_BITS-1], in_a[k]} - {in_p[k][COORD_BITS-1], in_p[k]};
         e_in[k] = {in_a[k][COORD_BITS-1], in_a[k]} - {in_b[k][COORD_BITS-1], in_b[k]};
      end
   end

   // magnitudes and per-axis products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dn[k]     = (~d_ff[k]) + DIFF_W'(1);
         en[k]     = (~e_ff[k]) + DIFF_W'(1);
         md[k]     = d_ff[k][DIFF_W-1] ? dn[k][MAG_W-1:0] : d_ff[k][MAG_W-1:0];
         me[k]     = e_ff[k][DIFF_W-1] ? en[k][MAG_W-1:0] : e_ff[k][MAG_W-1:0];
         neg_in[k] = d_ff[k][DIFF_W-1] ^ e_ff[k][DIFF_W-1];
         sqd_in[k] = SQ_W'(md[k]) * SQ_W'(md[k]);
         sqe_in[k] = SQ_W'(me[k]) * SQ_W'(me[k]);
         pr_in[k]  = SQ_W'(md[k]) * SQ_W'(me[k]);
      end
   end

   // squared lengths and signed dot product
   always_comb begin
      dd_in = '0;
      ee_in = '0;
      s_in  = '0;
      for (int k = 0; k < 3; k++) begin
         dd_in = dd_in + SUM_W'(sqd_ff[k]);
         ee_in = ee_in + SUM_W'(sqe_ff[k]);
         s_in  = neg_ff[k] ? (s_in - S_W'(pr_ff[k])) : (s_in + S_W'(pr_ff[k]));
      end
   end

   // absolute dot product
   always_comb begin
      s_neg  = (~s_ff) + S_W'(1);
      sab_in = s_ff[S_W-1] ? s_neg[SUM_W-1:0] : s_ff[SUM_W-1:0];
   end

   // wide products from half-width partial products
   always_comb begin
      pde_in = (NUM_W'(pe_hh_ff) << (2 * HALF_W)) + (NUM_W'(pe_hl_ff) << HALF_W)
             + (NUM_W'(pe_lh_ff) << HALF_W) + NUM_W'(pe_ll_ff);
      pss_in = (NUM_W'(ps_hh_ff) << (2 * HALF_W)) + (NUM_W'(ps_hl_ff) << HALF_W)
             + (NUM_W'(ps_lh_ff) << HALF_W) + NUM_W'(ps_ll_ff);
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff      <= d_in;
         e_ff      <= e_in;
         sqd_ff    <= sqd_in;
         sqe_ff    <= sqe_in;
         pr_ff     <= pr_in;
         neg_ff    <= neg_in;
         dd3_ff    <= dd_in;
         ee3_ff    <= ee_in;
         s_ff      <= s_in;
         sab_ff    <= sab_in;
         dd4_ff    <= dd3_ff;
         ee4_ff    <= ee3_ff;
         degen4_ff <= (ee3_ff == '0);
         pe_hh_ff  <= SUM_W'(dd4_ff[SUM_W-1:HALF_W]) * SUM_W'(ee4_ff[SUM_W-1:HALF_W]);
         pe_hl_ff  <= SUM_W'(dd4_ff[SUM_W-1:HALF_W]) * SUM_W'(ee4_ff[HALF_W-1:0]);
         pe_lh_ff  <= SUM_W'(dd4_ff[HALF_W-1:0]) * SUM_W'(ee4_ff[SUM_W-1:HALF_W]);
         pe_ll_ff  <= SUM_W'(dd4_ff[HALF_W-1:0]) * SUM_W'(ee4_ff[HALF_W-1:0]);
         ps_hh_ff  <= SUM_W'(sab_ff[SUM_W-1:HALF_W]) * SUM_W'(sab_ff[SUM_W-1:HALF_W]);
         ps_hl_ff  <= SUM_W'(sab_ff[SUM_W-1:HALF_W]) * SUM_W'(sab_ff[HALF_W-1:0]);
         ps_lh_ff  <= SUM_W'(sab_ff[HALF_W-1:0]) * SUM_W'(sab_ff[SUM_W-1:HALF_W]);
         ps_ll_ff  <= SUM_W'(sab_ff[HALF_W-1:0]) * SUM_W'(sab_ff[HALF_W-1:0]);
         dd5_ff    <= dd4_ff;
         ee5_ff    <= ee4_ff;
         degen5_ff <= degen4_ff;
         pde_ff    <= pde_in;
         pss_ff    <= pss_in;
         dd6_ff    <= dd5_ff;
         ee6_ff    <= ee5_ff;
         degen6_ff <= degen5_ff;
         // coincident anchors: divide |a-p|^2 by one
         num_ff    <= degen6_ff ? NUM_W'(dd6_ff) : (pde_ff - pss_ff);
         den_ff    <= degen6_ff ? SUM_W'(1) : ee6_ff;
         degen7_ff <= degen6_ff;
      end
   end

   assign out_ctl.valid = valid_ff[6];
   assign out_ctl.degen = degen7_ff;
   assign out_num       = num_ff;
   assign out_den       = den_ff;

endmodule

// File: rtl/plda_div.sv
// ------------------------------------------------------------------------
// plda_div
// restoring divider, one quotient bit per pipeline stage
// ------------------------------------------------------------------------
module plda_div import plda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  plda_ctl_type       in_ctl,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [SUM_W-1:0]   in_den,
   output plda_ctl_type       out_ctl,
   output logic [QUO_W-1:0]   out_quo
);

`include "point_line_distance_3d_macros.svh"

   plda_ctl_type     ctl_ff [QUO_W];
   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [SUM_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   plda_ctl_type     ctl_src [QUO_W];
   logic [NUM_W-1:0] rem_src [QUO_W];
   logic [SUM_W-1:0] den_src [QUO_W];
   logic [QUO_W-1:0] quo_src [QUO_W];

   assign ctl_src[0] = in_ctl;
   assign rem_src[0] = in_num;
   assign den_src[0] = in_den;
   assign quo_src[0] = '0;

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;
      logic [NUM_W-1:0] trial;
      logic             take;

      if (k > 0) begin : g_link
         assign ctl_src[k] = ctl_ff[k-1];
         assign rem_src[k] = rem_ff[k-1];
         assign den_src[k] = den_ff[k-1];
         assign quo_src[k] = quo_ff[k-1];
      end

      // compare against the shifted divisor
      always_comb begin
         trial = NUM_W'(den_src[k]) << BIT;
         take  = (rem_src[k] >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (advance) begin
            ctl_ff[k] <= ctl_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= take ? (rem_src[k] - trial) : rem_src[k];
            den_ff[k] <= den_src[k];
            quo_ff[k] <= quo_src[k] | (QUO_W'(take) << BIT);
         end
      end
   end

   assign out_ctl = ctl_ff[QUO_W-1];
   assign out_quo = quo_ff[QUO_W-1];

   `PLDA_ASSERT_IMP(a_rem_below_den, ctl_ff[QUO_W-1].valid, rem_ff[QUO_W-1] < NUM_W'(den_ff[QUO_W-1]), "divider remainder not below divisor")
   `PLDA_ASSERT_IMP(a_degen_unit_den, in_ctl.valid && in_ctl.degen, in_den == SUM_W'(1), "degenerate item without unit divisor")
   `PLDA_ASSERT_NXT(a_stall_holds, !advance && ctl_ff[QUO_W-1].valid, ctl_ff[QUO_W-1].valid && $stable(quo_ff[QUO_W-1]), "divider output changed while stalled")

endmodule

// File: rtl/plda_sqrt.sv
// ------------------------------------------------------------------------
// plda_sqrt
// integer square root, one root bit per pipeline stage
// ------------------------------------------------------------------------
module plda_sqrt import plda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  plda_ctl_type       in_ctl,
   input  logic [QUO_W-1:0]   in_rad,
   output plda_ctl_type       out_ctl,
   output logic [ROOT_W-1:0]  out_root
);

   plda_ctl_type     ctl_ff [ROOT_W];
   logic [QUO_W-1:0] x_ff   [ROOT_W];
   logic [QUO_W-1:0] res_ff [ROOT_W];

   plda_ctl_type     ctl_src [ROOT_W];
   logic [QUO_W-1:0] x_src   [ROOT_W];
   logic [QUO_W-1:0] res_src [ROOT_W];

   assign ctl_src[0] = in_ctl;
   assign x_src[0]   = in_rad;
   assign res_src[0] = '0;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int SHIFT = 2 * (ROOT_W - 1 - k);
      logic [QUO_W-1:0] one;
      logic [QUO_W-1:0] trial;
      logic             take;

      if (k > 0) begin : g_link
         assign ctl_src[k] = ctl_ff[k-1];
         assign x_src[k]   = x_ff[k-1];
         assign res_src[k] = res_ff[k-1];
      end

      // try the next root bit
      always_comb begin
         one   = QUO_W'(1) << SHIFT;
         trial = res_src[k] + one;
         take  = (x_src[k] >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (advance) begin
            ctl_ff[k] <= ctl_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[k]   <= take ? (x_src[k] - trial) : x_src[k];
            res_ff[k] <= take ? ((res_src[k] >> 1) + one) : (res_src[k] >> 1);
         end
      end
   end

   assign out_ctl  = ctl_ff[ROOT_W-1];
   assign out_root = res_ff[ROOT_W-1][ROOT_W-1:0];

endmodule

// File: rtl/point_line_distance_3d.sv
// ------------------------------------------------------------------------
// point_line_distance_3d
// perpendicular distance from a point to the line through two points
// ------------------------------------------------------------------------
// Accepts one transaction per clock and returns one result per transaction,
// in order, through seven front-end stages (differences, squares,
// dot product, split 42x42 products, numerator), 42 divider stages of one
// quotient bit each, 21 square-root stages of one root bit each and the
// output register. The whole pipeline freezes while a result waits to be
// taken. When both anchor points coincide, degenerate is set and the
// distance from the point to the first anchor is returned.
module point_line_distance_3d import plda_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   plda_req_if.sink     req_port,
   plda_rsp_if.source   rsp_port
);

   logic                       advance;
   logic [2:0][COORD_BITS-1:0] p, a, b;
   plda_ctl_type               front_ctl, div_ctl, sqrt_ctl;
   logic [NUM_W-1:0]           front_num;
   logic [SUM_W-1:0]           front_den;
   logic [QUO_W-1:0]           div_quo;
   logic [ROOT_W-1:0]          root;
   logic [MAX_W-1:0]           root_ext;
   logic [OUT_W-1:0]           dist_in, dist_ff;
   logic                       out_valid_ff, degen_ff;

   // pipeline moves when the output slot is free or being emptied
   assign advance        = !out_valid_ff || rsp_port.ready;
   assign req_port.ready = advance;

   assign p = {req_port.point_z, req_port.point_y, req_port.point_x};
   assign a = {req_port.anchor_a_z, req_port.anchor_a_y, req_port.anchor_a_x};
   assign b = {req_port.anchor_b_z, req_port.anchor_b_y, req_port.anchor_b_x};

   plda_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_port.valid),
      .in_p     (p),
      .in_a     (a),
      .in_b     (b),
      .out_ctl  (front_ctl),
      .out_num  (front_num),
      .out_den  (front_den)
   );

   plda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_ctl   (front_ctl),
      .in_num   (front_num),
      .in_den   (front_den),
      .out_ctl  (div_ctl),
      .out_quo  (div_quo)
   );

   plda_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_ctl   (div_ctl),
      .in_rad   (div_quo),
      .out_ctl  (sqrt_ctl),
      .out_root (root)
   );

   // saturate to the output field
   always_comb begin
      root_ext = MAX_W'(root);
      dist_in  = (root_ext > MAX_W'(OUT_MAX)) ? OUT_MAX : root_ext[OUT_W-1:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= sqrt_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff  <= dist_in;
         degen_ff <= sqrt_ctl.degen;
      end
   end

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.line_distance = dist_ff;
   assign rsp_port.degenerate    = degen_ff;

endmodule

// File: verif/plda_tb_if.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// plda_tb_if
// Testbench copy of the request and response channels. The design
// declares its own interfaces, so this file is kept to a note only.
// ------------------------------------------------------------------------
// the block's channel interfaces plda_req_if and plda_rsp_if are used as-is

// File: verif/tb_point_line_distance_3d.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_point_line_distance_3d
// Drives point and line transactions with random idling on both channels,
// predicts each distance with wide exact integer arithmetic and compares
// the responses in order.
// ------------------------------------------------------------------------
module tb_point_line_distance_3d;
   import plda_pkg::*;

   typedef struct {
      logic signed [19:0] c[9];
      logic               chk;
      logic [20:0]        dist_val;
      logic               degen;
   } stim_row_type;

   typedef struct {
      logic [20:0] dist_val;
      logic        degen;
   } dist_result_type;

   localparam int N_RANDOM = 1230;
   localparam int WATCHDOG = 20000;

   logic clock;
   logic reset;
   plda_req_if req_port ();
   plda_rsp_if rsp_port ();

   point_line_distance_3d dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port.sink),
      .rsp_port (rsp_port.source)
   );

   dist_result_type expected_q[$];
   int error_count;
   int sent_count;
   int recv_count;
   int degen_count;
   int idle_cycles;
   bit stim_done;
   bit no_idle;

   // clock generator
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // exact integer square root
   function automatic logic [127:0] int_sqrt(input logic [127:0] n);
      logic [127:0] root;
      logic [127:0] trial;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (128'd1 << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   // perpendicular distance of p to line through a and b
   function automatic dist_result_type predict_distance(input logic signed [19:0] c[9]);
      dist_result_type r;
      logic signed [127:0] d, e, dot;
      logic [127:0] dd, ee, num, root;
      dd = '0;
      ee = '0;
      dot = '0;
      for (int k = 0; k < 3; k++) begin
         d = 128'(c[3+k]) - 128'(c[k]);
         e = 128'(c[3+k]) - 128'(c[6+k]);
         dd += d * d;
         ee += e * e;
         dot += d * e;
      end
      r.degen = (ee == 0);
      if (r.degen) root = int_sqrt(dd);
      else begin
         num = dd * ee - dot * dot;
         root = int_sqrt(num / ee);
      end
      r.dist_val = (root > 128'd2097151) ? 21'h1FFFFF : root[20:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0d expected %0d (response %0d)", what, got, want,
               recv_count);
      error_count++;
   endtask

   // push one transaction through the request channel
   task automatic send_item(input logic signed [19:0] c[9], input dist_result_type want);
      while (!no_idle && $urandom_range(99) < 8) begin
         req_port.valid <= 1'b0;
         @(posedge clock);
      end
      req_port.valid      <= 1'b1;
      req_port.point_x    <= c[0];
      req_port.point_y    <= c[1];
      req_port.point_z    <= c[2];
      req_port.anchor_a_x <= c[3];
      req_port.anchor_a_y <= c[4];
      req_port.anchor_a_z <= c[5];
      req_port.anchor_b_x <= c[6];
      req_port.anchor_b_y <= c[7];
      req_port.anchor_b_z <= c[8];
      do @(posedge clock); while (!req_port.ready);
      expected_q = {expected_q, want};
      sent_count++;
   endtask

   function automatic logic signed [19:0] rand_coord(input int mode);
      case (mode)
         0: return 20'($urandom);
         1: return $urandom_range(1) ? 20'h7FFFF : 20'h80000;
         default: return 20'($signed($urandom_range(2048)) - 1024);
      endcase
   endfunction

   // stimulus
   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      logic signed [19:0] c[9];
      dist_result_type want;
      dist_result_type pred;
      int mode;
      reset = 1'b1;
      req_port.valid = 1'b0;
      {req_port.point_x, req_port.point_y, req_port.point_z} = '0;
      {req_port.anchor_a_x, req_port.anchor_a_y, req_port.anchor_a_z} = '0;
      {req_port.anchor_b_x, req_port.anchor_b_y, req_port.anchor_b_z} = '0;
      error_count = 0;
      sent_count = 0;
      recv_count = 0;
      degen_count = 0;
      stim_done = 1'b0;
      no_idle = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: all zero, unit offsets, extremes, coincident anchors
      row.c = '{default: 20'sd0};
      row.chk = 1'b1; row.dist_val = 21'd0; row.degen = 1'b1;
      rows = {rows, row};
      row.c = '{20'sd0, 20'sd0, 20'sd0, 20'sd256, 20'sd0, 20'sd0,
                20'sd256, 20'sd0, 20'sd0};
      row.dist_val = 21'd256; row.degen = 1'b1;
      rows = {rows, row};
      row.c = '{20'sd0, 20'sd256, 20'sd0, 20'sd0, 20'sd0, 20'sd0,
                20'sd256, 20'sd0, 20'sd0};
      row.dist_val = 21'd256; row.degen = 1'b0;
      rows = {rows, row};
      row.c = '{20'sd5, 20'sd5, 20'sd5, 20'sd0, 20'sd0, 20'sd0,
                20'sd7, 20'sd7, 20'sd7};
      row.dist_val = 21'd0; row.degen = 1'b0;
      rows = {rows, row};
      row.chk = 1'b0;
      row.c = '{default: -20'sd524288};
      rows = {rows, row};
      row.c = '{default: 20'sd524287};
      rows = {rows, row};
      row.c = '{-20'sd524288, -20'sd524288, -20'sd524288, 20'sd524287, 20'sd524287,
                20'sd524287, 20'sd524287, 20'sd524287, 20'sd524287};
      rows = {rows, row};
      row.c = '{20'sd524287, -20'sd524288, 20'sd524287, -20'sd524288, 20'sd524287,
                -20'sd524288, 20'sd524287, 20'sd524287, -20'sd524288};
      rows = {rows, row};
      row.c = '{-20'sd524288, 20'sd524287, -20'sd524288, 20'sd524287, -20'sd524288,
                20'sd524287, 20'sd524287, -20'sd524288, -20'sd524288};
      rows = {rows, row};
      row.c = '{20'sd1, -20'sd1, 20'sd1, -20'sd1, 20'sd1, -20'sd1, -20'sd1, 20'sd1, -20'sd1};
      rows = {rows, row};
      row.c = '{20'sd3, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd1};
      rows = {rows, row};
      foreach (rows[i]) begin
         pred = predict_distance(rows[i].c);
         if (rows[i].chk) begin
            // typed expectation is what the response is held to
            want.dist_val = rows[i].dist_val;
            want.degen    = rows[i].degen;
            if (pred.dist_val != want.dist_val)
               report_mismatch("table row distance vs predictor",
                               32'(pred.dist_val), 32'(want.dist_val));
            if (pred.degen != want.degen)
               report_mismatch("table row degenerate vs predictor",
                               32'(pred.degen), 32'(want.degen));
         end else begin
            want = pred;
         end
         send_item(rows[i].c, want);
      end

      // random part: mixed ranges, some coincident anchors
      for (int n = 0; n < N_RANDOM; n++) begin
         no_idle = (n >= 400 && n < 600);
         mode = $urandom_range(9);
         for (int k = 0; k < 9; k++)
            c[k] = rand_coord(mode < 4 ? 0 : (mode == 4 ? 1 : 2));
         if ($urandom_range(9) == 0)
            for (int k = 0; k < 3; k++) c[6+k] = c[3+k];
         send_item(c, predict_distance(c));
      end
      req_port.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // response side: random stalls and in-order compare
   always @(posedge clock) begin
      dist_result_type want;
      if (reset) begin
         rsp_port.ready <= 1'b0;
      end else begin
         if (rsp_port.valid && rsp_port.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected transaction", 32'(rsp_port.line_distance), 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_port.line_distance !== want.dist_val)
                  report_mismatch("line_distance", 32'(rsp_port.line_distance),
                                  32'(want.dist_val));
               if (rsp_port.degenerate !== want.degen)
                  report_mismatch("degenerate", 32'(rsp_port.degenerate),
                                  32'(want.degen));
               if (want.degen) degen_count++;
            end
            recv_count++;
         end
         rsp_port.ready <= no_idle || ($urandom_range(99) >= 8);
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_port.valid && req_port.ready) ||
          (rsp_port.valid && rsp_port.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // end of run
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d responses outstanding", expected_q.size());
            $display("DONE: errors detected");
            $finish;
         end
         if (stim_done && expected_q.size() == 0) break;
      end
      repeat (100) @(posedge clock);
      $display("covered %0d transactions, %0d responses, %0d with coincident anchors",
               sent_count, recv_count, degen_count);
      $display("random points across full range, extremes and short spans");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/plda_pkg.sv
rtl/plda_if.sv
rtl/plda_front.sv
rtl/plda_div.sv
rtl/plda_sqrt.sv
rtl/point_line_distance_3d.sv
verif/plda_tb_if.sv
verif/tb_point_line_distance_3d.sv
